@@ rtl/core/iwq_pkg.sv @@
// Package for the int8 weight quantizer: payload, configuration, job and
// handshake structs, register indexes and a shared arithmetic helper.
// No dependencies.
package iwq_pkg;

   localparam int CNT_W = 7;
   localparam int QSCALE = 127;

   localparam logic [2:0] CSR_IN_SCALE         = 3'd0;
   localparam logic [2:0] CSR_INPUT_ZERO       = 3'd1;
   localparam logic [2:0] CSR_OUTPUT_INV_SCALE = 3'd2;
   localparam logic [2:0] CSR_OUTPUT_ZERO      = 3'd3;
   localparam logic [2:0] CSR_SUM_SCALE        = 3'd4;
   localparam logic [2:0] CSR_SUM_ZERO         = 3'd5;
   localparam logic [2:0] CSR_MODE             = 3'd6;

   localparam int MODE_BIAS  = 0;
   localparam int MODE_FLOAT = 1;
   localparam int MODE_SUM   = 2;

   typedef struct packed {
      logic signed [31:0] weight;
      logic signed [31:0] bias;
      logic               last_weight;
   } req_type;

   typedef struct packed {
      logic signed [7:0]  quant_weight;
      logic [31:0]        channel_scale;
      logic signed [47:0] compensation;
      logic               zero_channel;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [31:0] in_scale;
      logic [7:0]  input_zero;
      logic [31:0] output_inv_scale;
      logic [7:0]  output_zero;
      logic [31:0] sum_scale;
      logic [7:0]  sum_zero;
      logic [2:0]  mode;
   } cfg_type;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic [31:0]      absmax;
      logic [31:0]      bias;
   } job_type;

   typedef struct packed {
      logic             en;
      logic             bank;
      logic [CNT_W-1:0] idx;
      logic [31:0]      data;
   } wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

@@ rtl/core/iwq_front.sv @@
// Front end: accepts weight transactions, builds store writes, tracks the
// running absmax and issues one job per channel. Depends on iwq_pkg.
module iwq_front #(
   parameter int MAX_WEIGHTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iwq_pkg::req_type req_data,
   input  iwq_pkg::done_type done,
   output iwq_pkg::wr_type  wr,
   output logic             push,
   output iwq_pkg::job_type push_job
);
   import iwq_pkg::*;

   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      absmax_ff, absmax_in;
   logic             accept, room;
   logic [31:0]      wmag;
   logic [CNT_W-1:0] count_nx;
   logic [31:0]      absmax_nx;

   assign req_ready = !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < CNT_W'(MAX_WEIGHTS);
   assign wmag      = mag32(req_data.weight);
   assign count_nx  = room ? count_ff + CNT_W'(1) : count_ff;
   assign absmax_nx = (room && wmag > absmax_ff) ? wmag : absmax_ff;

   always_comb begin
      wr.en   = accept && room;
      wr.bank = bank_ff;
      wr.idx  = count_ff;
      wr.data = req_data.weight;
      push    = accept && req_data.last_weight;
      push_job.bank   = bank_ff;
      push_job.count  = count_nx;
      push_job.absmax = absmax_nx;
      push_job.bias   = req_data.bias;
   end

   always_comb begin
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      count_in  = count_ff;
      absmax_in = absmax_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         count_in  = count_nx;
         absmax_in = absmax_nx;
         if (req_data.last_weight) begin
            count_in  = '0;
            absmax_in = '0;
            busy_in[bank_ff] = 1'b1;
            bank_in   = !bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
         count_ff  <= '0;
         absmax_ff <= '0;
      end else begin
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         absmax_ff <= absmax_in;
      end
   end

endmodule

@@ rtl/core/iwq_queue.sv @@
// Two-entry job queue between front and back end. Depends on iwq_pkg.
module iwq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  iwq_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output iwq_pkg::job_type head_job
);
   import iwq_pkg::*;

   job_type    slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = cnt_ff != 2'd0;
   assign head_job   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/iwq_back.sv @@
// Back end: two-bank weight store, channel scale (shared multiplier and a
// shift-and-add divide by 127), per-weight quantizing divider and compensation.
// Depends on iwq_pkg.
module iwq_back #(
   parameter int MAX_WEIGHTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  iwq_pkg::cfg_type  cfg,
   input  iwq_pkg::wr_type   wr,
   input  logic              job_valid,
   input  iwq_pkg::job_type  job,
   output iwq_pkg::done_type done,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iwq_pkg::rsp_type  rsp_data
);
   import iwq_pkg::*;

   localparam int AW = $clog2(2 * MAX_WEIGHTS);
   localparam int IW = $clog2(MAX_WEIGHTS);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_MSA   = 16'h0002,
      ST_MLO   = 16'h0004,
      ST_MHI   = 16'h0008,
      ST_SUM   = 16'h0010,
      ST_DIVC  = 16'h0020,
      ST_RD    = 16'h0040,
      ST_LOAD  = 16'h0080,
      ST_DIV   = 16'h0100,
      ST_RND   = 16'h0200,
      ST_IZQ   = 16'h0400,
      ST_CIZQ  = 16'h0800,
      ST_CBIAS = 16'h1000,
      ST_CSZ   = 16'h2000,
      ST_CFIN  = 16'h4000,
      ST_EMIT  = 16'h8000
   } back_state_type;

   logic [31:0] store [2*MAX_WEIGHTS];
   logic [31:0] rdata_ff;
   logic [AW-1:0] waddr, raddr;

   back_state_type     st_ff, st_in;
   logic [63:0]        sa_ff, plo_ff, phi_ff;
   logic [38:0]        dy_ff;
   logic [31:0]        dacc_ff;
   logic               dsat_ff;
   logic [31:0]        scale_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [38:0]        num_ff;
   logic [6:0]         quo_ff;
   logic [2:0]         k_ff;
   logic               neg_ff, zero_ff, last_ff;
   logic signed [7:0]  q_ff;
   logic signed [13:0] qsum_ff;
   logic [22:0]        izq_ff;
   logic               izq_neg_ff;
   logic [63:0]        t1_ff, szt_ff;
   logic signed [63:0] bt_ff;
   logic signed [47:0] comp_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        load_out;

   assign waddr = AW'(wr.idx[IW-1:0]) + (wr.bank ? AW'(MAX_WEIGHTS) : AW'(0));
   assign raddr = AW'(idx_ff[IW-1:0]) + (job.bank ? AW'(MAX_WEIGHTS) : AW'(0));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store[waddr] <= wr.data;
      end
      rdata_ff <= store[raddr];
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (st_ff)
         ST_MSA: begin
            mul_a = job.absmax;
            mul_b = cfg.in_scale;
         end
         ST_MLO: begin
            mul_a = sa_ff[31:0];
            mul_b = cfg.output_inv_scale;
         end
         ST_MHI: begin
            mul_a = sa_ff[63:32];
            mul_b = cfg.output_inv_scale;
         end
         ST_CIZQ: begin
            mul_a = {9'd0, izq_ff};
            mul_b = scale_ff;
         end
         ST_CBIAS: begin
            mul_a = mag32(job.bias);
            mul_b = cfg.output_inv_scale;
         end
         ST_CSZ: begin
            mul_a = {24'd0, cfg.sum_zero};
            mul_b = cfg.sum_scale;
         end
         default: begin
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // quantizer helpers
   logic [38:0] dshift;
   logic        qge;
   logic        rup;
   logic [7:0]  quo_r;
   logic signed [7:0] q_nx;
   logic signed [22:0] izq_p;
   logic [63:0] sum_t, sum_sh, sum_f, dvd;
   logic [48:0] bround;
   logic signed [63:0] csum;

   assign dshift = {7'd0, job.absmax} << k_ff;
   assign qge    = num_ff >= dshift;
   assign rup    = ({num_ff, 1'b0} > {8'd0, job.absmax})
                || (({num_ff, 1'b0} == {8'd0, job.absmax}) && quo_ff[0]);
   assign quo_r  = zero_ff ? 8'd0 : ({1'b0, quo_ff} + 8'(rup));
   assign q_nx   = neg_ff ? -$signed(quo_r) : $signed(quo_r);
   assign izq_p  = $signed({1'b0, cfg.input_zero}) * qsum_ff;
   assign sum_t  = {32'd0, plo_ff[31:0]} + 64'(64'd127 << 31);
   assign sum_sh = phi_ff + {32'd0, plo_ff[63:32]} + {32'd0, sum_t[63:32]};
   assign sum_f  = (sa_ff + 64'(QSCALE * 32768)) >> 16;
   assign dvd    = cfg.mode[MODE_FLOAT] ? sum_f : sum_sh;
   assign bround = 49'((mul_p + 64'd32768) >> 16);

   always_comb begin
      csum = bt_ff - (izq_neg_ff ? -$signed(t1_ff) : $signed(t1_ff))
           - $signed(szt_ff);
      if (!cfg.mode[MODE_FLOAT]) begin
         csum = csum + $signed({40'd0, cfg.output_zero, 16'd0});
      end
   end

   assign load_out = (st_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (job_valid) st_in = ST_MSA;
         ST_MSA:   st_in = cfg.mode[MODE_FLOAT] ? ST_SUM : ST_MLO;
         ST_MLO:   st_in = ST_MHI;
         ST_MHI:   st_in = ST_SUM;
         ST_SUM:   st_in = ST_DIVC;
         ST_DIVC:  if (dy_ff[38:7] == 32'd0) st_in = ST_RD;
         ST_RD:    st_in = ST_LOAD;
         ST_LOAD:  st_in = ST_DIV;
         ST_DIV:   if (k_ff == 3'd0) st_in = ST_RND;
         ST_RND:   st_in = (idx_ff == job.count - CNT_W'(1)) ? ST_IZQ : ST_EMIT;
         ST_IZQ:   st_in = ST_CIZQ;
         ST_CIZQ:  st_in = ST_CBIAS;
         ST_CBIAS: st_in = ST_CSZ;
         ST_CSZ:   st_in = ST_CFIN;
         ST_CFIN:  st_in = ST_EMIT;
         ST_EMIT: begin
            if (load_out) st_in = last_ff ? ST_IDLE : ST_RD;
         end
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      done.valid = load_out && last_ff;
      done.bank  = job.bank;
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: begin
            zero_ff <= job.absmax == 32'd0;
         end
         ST_MSA: sa_ff <= mul_p;
         ST_MLO: plo_ff <= mul_p;
         ST_MHI: phi_ff <= mul_p;
         ST_SUM: begin
            // quotient saturates once the dividend reaches 127 * 2^32
            dsat_ff <= dvd >= 64'h0000_007F_0000_0000;
            dy_ff   <= dvd[38:0];
            dacc_ff <= '0;
         end
         ST_DIVC: begin
            // 128 = 127 + 1: fold the high part back into the low digits
            if (dy_ff[38:7] == 32'd0) begin
               scale_ff <= dsat_ff ? 32'hFFFF_FFFF
                                   : dacc_ff + {31'd0, dy_ff == 39'd127};
               idx_ff   <= '0;
               qsum_ff  <= '0;
            end else begin
               dacc_ff <= dacc_ff + dy_ff[38:7];
               dy_ff   <= {7'd0, dy_ff[38:7]} + {32'd0, dy_ff[6:0]};
            end
         end
         ST_LOAD: begin
            num_ff <= {mag32(rdata_ff), 7'd0} - {7'd0, mag32(rdata_ff)};
            neg_ff <= rdata_ff[31];
            quo_ff <= '0;
            k_ff   <= 3'd6;
         end
         ST_DIV: begin
            if (qge) begin
               num_ff <= num_ff - dshift;
            end
            quo_ff[k_ff] <= qge;
            k_ff <= k_ff - 3'd1;
         end
         ST_RND: begin
            q_ff    <= q_nx;
            qsum_ff <= qsum_ff + 14'(q_nx);
            last_ff <= idx_ff == job.count - CNT_W'(1);
         end
         ST_IZQ: begin
            izq_neg_ff <= izq_p[22];
            izq_ff     <= izq_p[22] ? 23'(-izq_p) : 23'(izq_p);
         end
         ST_CIZQ: t1_ff <= mul_p;
         ST_CBIAS: begin
            if (!cfg.mode[MODE_BIAS]) begin
               bt_ff <= '0;
            end else if (cfg.mode[MODE_FLOAT]) begin
               bt_ff <= 64'($signed(job.bias));
            end else begin
               bt_ff <= job.bias[31] ? -$signed({15'd0, bround})
                                     : $signed({15'd0, bround});
            end
         end
         ST_CSZ: szt_ff <= cfg.mode[MODE_SUM] ? mul_p : 64'd0;
         ST_CFIN: begin
            if (csum > 64'sh0000_7FFF_FFFF_FFFF) begin
               comp_ff <= 48'sh7FFF_FFFF_FFFF;
            end else if (csum < -64'sh0000_8000_0000_0000) begin
               comp_ff <= 48'sh8000_0000_0000;
            end else begin
               comp_ff <= 48'(csum);
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      if (load_out) begin
         rsp_ff.quant_weight  <= q_ff;
         rsp_ff.channel_scale <= last_ff ? scale_ff : 32'd0;
         rsp_ff.compensation  <= last_ff ? comp_ff : 48'sd0;
         rsp_ff.zero_channel  <= zero_ff;
         rsp_ff.last_result   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/int8_weight_quantizer_top.sv @@
// Symmetric per-channel int8 weight quantizer, top level with CSR block.
// Weight transactions are taken at one per cycle, while the bank being filled
// is not busy, into a two-bank store while the other bank is processed; a
// channel of n weights then takes the scale (shift-and-add divide by 127), a
// quantizing divide and rounding for each weight and the compensation, plus
// any result stall. Synchronous active-high reset clears control state and
// restores the CSR defaults; the store is not cleared.
module int8_weight_quantizer_top #(
   parameter int MAX_WEIGHTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iwq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iwq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import iwq_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   wr_type   wr;
   logic     push, head_valid;
   job_type  push_job, head_job;
   done_type done;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IN_SCALE:         cfg_in.in_scale         = csr_data;
            CSR_INPUT_ZERO:       cfg_in.input_zero       = csr_data[7:0];
            CSR_OUTPUT_INV_SCALE: cfg_in.output_inv_scale = csr_data;
            CSR_OUTPUT_ZERO:      cfg_in.output_zero      = csr_data[7:0];
            CSR_SUM_SCALE:        cfg_in.sum_scale        = csr_data;
            CSR_SUM_ZERO:         cfg_in.sum_zero         = csr_data[7:0];
            CSR_MODE:             cfg_in.mode             = csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_scale         <= 32'd65536;
         cfg_ff.input_zero       <= '0;
         cfg_ff.output_inv_scale <= 32'd65536;
         cfg_ff.output_zero      <= '0;
         cfg_ff.sum_scale        <= 32'd65536;
         cfg_ff.sum_zero         <= '0;
         cfg_ff.mode             <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iwq_front #(.MAX_WEIGHTS(MAX_WEIGHTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .done      (done),
      .wr        (wr),
      .push      (push),
      .push_job  (push_job)
   );

   iwq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (done.valid),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   iwq_back #(.MAX_WEIGHTS(MAX_WEIGHTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .wr        (wr),
      .job_valid (head_valid),
      .job       (head_job),
      .done      (done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
